FILE: hdl/bj3_pkg.sv
// ----------------------------------------------------------------------------
// bj3_pkg
// Types and constants for the 3x3 block-Jacobi update core.
// ----------------------------------------------------------------------------
`default_nettype none

package bj3_pkg;

	localparam int WEIGHT_W = 17;
	localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd21845;
	localparam int REG_WEIGHT = 0;

	// Front stages, divider steps, output register
	localparam int FRONT_STAGES = 8;
	localparam int DIV_STEPS = 34;
	localparam int NSTG = FRONT_STAGES + DIV_STEPS + 1;

	localparam int NUM_W = 113;
	localparam int DEN_W = 96;
	localparam int TRIAL_W = 130;

	// Cofactor k = a[PA]*a[PB] - a[MA]*a[MB], row-major entries
	localparam int CF_PA [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
	localparam int CF_PB [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
	localparam int CF_MA [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
	localparam int CF_MB [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

	typedef struct packed {
		logic [NUM_W-1:0]     rem;
		logic [DEN_W-1:0]     den;
		logic [DIV_STEPS-1:0] quo;
		logic                 neg;
		logic                 zero;
	} dv_lane_t;

endpackage

`default_nettype wire

FILE: hdl/block_jacobi_3x3_update_core.sv
// ----------------------------------------------------------------------------
// block_jacobi_3x3_update_core
// Block-Jacobi correction omega * inv(H) * g per node, scalar fallback when
// the block is singular, Q16.16 with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: in_valid / in_stall with the nine block entries h00..h22
//   and the gradient grad_0..grad_2. A request is taken on a rising edge with
//   in_valid high and in_stall low.
//   Result channel: out_valid / out_stall with delta_0..delta_2 and
//   used_fallback, taken on a rising edge with out_valid high, out_stall low.
//   One request per cycle is taken and one result per cycle delivered while
//   neither channel stalls. The pipeline has eight stages of products,
//   cofactor, determinant and scaling, then a 34-step restoring divider, one
//   quotient bit per stage, and the output register.
//   Each stage holds while the one after it is full and held, so a stall from
//   the receiver backs up only as far as the pipeline is full; in_stall rises
//   when every stage holds a request and the receiver stalls.
//   Reset clears all stage valid bits and sets the weight to 21845.
//   The weight register sits at APB byte address 0; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module block_jacobi_3x3_update_core
	import bj3_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [31:0] h00,
	input  wire logic signed [31:0] h01,
	input  wire logic signed [31:0] h02,
	input  wire logic signed [31:0] h10,
	input  wire logic signed [31:0] h11,
	input  wire logic signed [31:0] h12,
	input  wire logic signed [31:0] h20,
	input  wire logic signed [31:0] h21,
	input  wire logic signed [31:0] h22,
	input  wire logic signed [31:0] grad_0,
	input  wire logic signed [31:0] grad_1,
	input  wire logic signed [31:0] grad_2,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [31:0]      delta_0,
	output logic signed [31:0]      delta_1,
	output logic signed [31:0]      delta_2,
	output logic                    used_fallback
);

	function automatic dv_lane_t div_step(input dv_lane_t x, input int i);
		logic [TRIAL_W-1:0] t;
		dv_lane_t r;
		r = x;
		t = {{(TRIAL_W-NUM_W){1'b0}}, x.rem} - ({{(TRIAL_W-DEN_W){1'b0}}, x.den} << i);
		if (!t[TRIAL_W-1]) begin
			r.rem = t[NUM_W-1:0];
			r.quo[i] = 1'b1;
		end
		return r;
	endfunction

	function automatic logic [31:0] finish(input dv_lane_t x);
		logic [31:0] r;
		if (x.zero) begin
			r = '0;
		end else if (!x.neg) begin
			r = (x.quo > 34'h07FFF_FFFF) ? 32'h7FFF_FFFF : x.quo[31:0];
		end else begin
			r = (x.quo > 34'h08000_0000) ? 32'h8000_0000 : 32'd0 - x.quo[31:0];
		end
		return r;
	endfunction

	// configuration
	logic [WEIGHT_W-1:0] weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_q <= WEIGHT_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'(REG_WEIGHT)) begin
			weight_q <= pwdata[WEIGHT_W-1:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'(REG_WEIGHT)) ? {{(32-WEIGHT_W){1'b0}}, weight_q} : 32'd0;

	// stage valid bits and per-stage load enables
	logic [NSTG-1:0] vld_q;
	logic [NSTG-1:0] en;

	assign en[NSTG-1] = !vld_q[NSTG-1] || !out_stall;
	for (genvar i = 0; i < NSTG - 1; i++) begin : g_en
		assign en[i] = !vld_q[i] || en[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[NSTG-2:0], in_valid}) | (~en & vld_q);
		end
	end

	assign in_stall = !en[0];
	assign out_valid = vld_q[NSTG-1];

	logic signed [31:0] av [9];
	logic signed [31:0] gv [3];
	assign av = '{h00, h01, h02, h10, h11, h12, h20, h21, h22};
	assign gv = '{grad_0, grad_1, grad_2};

	// s1: cofactor products, weighted gradient
	logic signed [63:0] pp_s1 [9];
	logic signed [63:0] pm_s1 [9];
	logic signed [31:0] row0_s1 [3];
	logic signed [31:0] g_s1 [3];
	logic signed [31:0] diag_s1 [3];
	logic signed [49:0] wg_s1 [3];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int k = 0; k < 9; k++) begin
				pp_s1[k] <= av[CF_PA[k]] * av[CF_PB[k]];
				pm_s1[k] <= av[CF_MA[k]] * av[CF_MB[k]];
			end
			for (int k = 0; k < 3; k++) begin
				row0_s1[k] <= av[k];
				g_s1[k] <= gv[k];
				diag_s1[k] <= av[4*k];
				wg_s1[k] <= $signed({1'b0, weight_q}) * gv[k];
			end
		end
	end

	// s2: cofactors
	logic signed [63:0] c_s2 [9];
	logic signed [31:0] row0_s2 [3];
	logic signed [31:0] g_s2 [3];
	logic signed [31:0] diag_s2 [3];
	logic signed [49:0] wg_s2 [3];

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int k = 0; k < 9; k++) c_s2[k] <= pp_s1[k] - pm_s1[k];
			row0_s2 <= row0_s1;
			g_s2 <= g_s1;
			diag_s2 <= diag_s1;
			wg_s2 <= wg_s1;
		end
	end

	// s3: 32x64 products split into two halves; terms 0..2 give the determinant
	logic signed [31:0] xs [12];
	logic signed [63:0] cs [12];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			xs[j] = row0_s2[j];
			cs[j] = c_s2[3*j];
		end
		for (int l = 0; l < 3; l++) begin
			for (int m = 0; m < 3; m++) begin
				xs[3 + 3*l + m] = g_s2[m];
				cs[3 + 3*l + m] = c_s2[3*l + m];
			end
		end
	end

	logic signed [63:0] ph_s3 [12];
	logic signed [64:0] pl_s3 [12];
	logic signed [31:0] diag_s3 [3];
	logic signed [49:0] wg_s3 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 12; j++) begin
				ph_s3[j] <= xs[j] * $signed(cs[j][63:32]);
				pl_s3[j] <= xs[j] * $signed({1'b0, cs[j][31:0]});
			end
			diag_s3 <= diag_s2;
			wg_s3 <= wg_s2;
		end
	end

	// s4: recombine halves
	logic signed [95:0] full_s4 [12];
	logic signed [31:0] diag_s4 [3];
	logic signed [49:0] wg_s4 [3];

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int j = 0; j < 12; j++) begin
				full_s4[j] <= $signed({ph_s3[j], 32'd0}) + 96'(pl_s3[j]);
			end
			diag_s4 <= diag_s3;
			wg_s4 <= wg_s3;
		end
	end

	// s5: determinant and adjugate-times-gradient sums
	logic signed [96:0] sum_s5 [4];
	logic signed [31:0] diag_s5 [3];
	logic signed [49:0] wg_s5 [3];

	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int l = 0; l < 4; l++) begin
				sum_s5[l] <= 97'(full_s4[3*l]) + 97'(full_s4[3*l+1]) + 97'(full_s4[3*l+2]);
			end
			diag_s5 <= diag_s4;
			wg_s5 <= wg_s4;
		end
	end

	// s6: magnitudes and signs
	logic [95:0] nmag_s6 [3];
	logic [95:0] dmag_s6;
	logic        bneg_s6 [3];
	logic        det_zero_s6;
	logic [48:0] fnum_s6 [3];
	logic [31:0] fden_s6 [3];
	logic        fneg_s6 [3];
	logic        fzero_s6 [3];

	logic signed [96:0] neg_sum [4];
	logic signed [49:0] neg_wg [3];
	logic signed [31:0] neg_diag [3];

	always_comb begin
		for (int l = 0; l < 4; l++) neg_sum[l] = -sum_s5[l];
		for (int k = 0; k < 3; k++) begin
			neg_wg[k] = -wg_s5[k];
			neg_diag[k] = -diag_s5[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en[5]) begin
			dmag_s6 <= sum_s5[0][96] ? neg_sum[0][95:0] : sum_s5[0][95:0];
			det_zero_s6 <= (sum_s5[0] == '0);
			for (int k = 0; k < 3; k++) begin
				nmag_s6[k] <= sum_s5[k+1][96] ? neg_sum[k+1][95:0] : sum_s5[k+1][95:0];
				bneg_s6[k] <= sum_s5[k+1][96] ^ sum_s5[0][96];
				fnum_s6[k] <= wg_s5[k][49] ? neg_wg[k][48:0] : wg_s5[k][48:0];
				// the most negative entry keeps its bits as an unsigned magnitude
				fden_s6[k] <= diag_s5[k][31] ? neg_diag[k] : diag_s5[k];
				fneg_s6[k] <= wg_s5[k][49] ^ diag_s5[k][31];
				fzero_s6[k] <= (diag_s5[k] == '0);
			end
		end
	end

	// s7: scale numerator magnitudes by the weight in 32-bit slices
	logic [48:0] mp_s7 [3][3];
	logic [95:0] dmag_s7;
	logic        bneg_s7 [3];
	logic        det_zero_s7;
	logic [48:0] fnum_s7 [3];
	logic [31:0] fden_s7 [3];
	logic        fneg_s7 [3];
	logic        fzero_s7 [3];

	always_ff @(posedge clk) begin
		if (en[6]) begin
			for (int l = 0; l < 3; l++) begin
				for (int m = 0; m < 3; m++) begin
					mp_s7[l][m] <= nmag_s6[l][32*m +: 32] * weight_q;
				end
			end
			dmag_s7 <= dmag_s6;
			bneg_s7 <= bneg_s6;
			det_zero_s7 <= det_zero_s6;
			fnum_s7 <= fnum_s6;
			fden_s7 <= fden_s6;
			fneg_s7 <= fneg_s6;
			fzero_s7 <= fzero_s6;
		end
	end

	// s8 and divider steps: dv_sd[0] is the s8 register
	dv_lane_t dv_sd [DIV_STEPS+1][3];
	logic     fb_sd [DIV_STEPS+1];

	always_ff @(posedge clk) begin
		if (en[FRONT_STAGES-1]) begin
			fb_sd[0] <= det_zero_s7;
			for (int l = 0; l < 3; l++) begin
				dv_sd[0][l].quo <= '0;
				if (det_zero_s7) begin
					dv_sd[0][l].rem <= NUM_W'(fnum_s7[l]);
					dv_sd[0][l].den <= DEN_W'(fden_s7[l]);
					dv_sd[0][l].neg <= fneg_s7[l];
					dv_sd[0][l].zero <= fzero_s7[l];
				end else begin
					dv_sd[0][l].rem <= NUM_W'(mp_s7[l][0]) + NUM_W'({mp_s7[l][1], 32'd0})
						+ {mp_s7[l][2], 64'd0};
					dv_sd[0][l].den <= dmag_s7;
					dv_sd[0][l].neg <= bneg_s7[l];
					dv_sd[0][l].zero <= 1'b0;
				end
			end
		end
	end

	// one quotient bit per stage, most significant first
	for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_div
		always_ff @(posedge clk) begin
			if (en[FRONT_STAGES-1+j]) begin
				fb_sd[j] <= fb_sd[j-1];
				for (int l = 0; l < 3; l++) dv_sd[j][l] <= div_step(dv_sd[j-1][l], DIV_STEPS - j);
			end
		end
	end

	// output register: sign and saturate
	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			delta_0 <= finish(dv_sd[DIV_STEPS][0]);
			delta_1 <= finish(dv_sd[DIV_STEPS][1]);
			delta_2 <= finish(dv_sd[DIV_STEPS][2]);
			used_fallback <= fb_sd[DIV_STEPS];
		end
	end

	// input is held back only when every stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> &vld_q)
		else $error("input held with a free stage");

	// a quotient that did not overflow leaves a remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG-2] && !dv_sd[DIV_STEPS][0].quo[DIV_STEPS-1]
			&& dv_sd[DIV_STEPS][0].den != '0)
		|-> (dv_sd[DIV_STEPS][0].rem < NUM_W'(dv_sd[DIV_STEPS][0].den)))
		else $error("divider remainder not reduced");

	// a zero diagonal in the fallback gives a zero correction
	a_zero_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q[NSTG-2] && en[NSTG-1] && dv_sd[DIV_STEPS][0].zero) |=> (delta_0 == '0))
		else $error("zero-diagonal lane not cleared");

endmodule

`default_nettype wire
